// ===== rtl/emr_pkg.sv =====
// Shared constants, field widths, codes and the point handoff type for the
// midpoint ellipse rasterizer. No dependencies.
package emr_pkg;

  // radius width; all internal arithmetic widths follow from it
  localparam int RADIUS_BITS = 10;

  // fixed field widths of the stream and config payloads
  localparam int FIELD_W    = 10;
  localparam int COORD_W    = 10;
  localparam int COLOUR_W   = 4;
  localparam int PIX_W      = 12;
  localparam int IN_DATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * PIX_W + COLOUR_W + 7) / 8) * 8;

  // internal arithmetic widths
  localparam int POINT_W = RADIUS_BITS + 1;
  localparam int SQ_W    = 2 * RADIUS_BITS;
  localparam int GRAD_W  = 3 * RADIUS_BITS + 4;
  localparam int DEC_W   = 4 * RADIUS_BITS + 4;
  localparam int ACC_W   = DEC_W + 2;
  localparam int MUL_W   = 2 * RADIUS_BITS + 4;
  localparam int PROD_W  = 2 * MUL_W;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR   = 2'd2;

  localparam logic [COORD_W-1:0]  CENTER_X_RST = 10'd200;
  localparam logic [COORD_W-1:0]  CENTER_Y_RST = 10'd200;
  localparam logic [COLOUR_W-1:0] COLOUR_RST   = 4'd15;

  // request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // pixel order within a point
  localparam logic [1:0] PIX_PP = 2'd0;  // (+x, +y)
  localparam logic [1:0] PIX_MM = 2'd1;  // (-x, -y)
  localparam logic [1:0] PIX_PM = 2'd2;  // (+x, -y)
  localparam logic [1:0] PIX_MP = 2'd3;  // (-x, +y), last of the point

  // point handed from the walker to the pixel emitter
  typedef struct packed {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic               done;
  } point_t;

endpackage

// ===== rtl/emr_mul.sv =====
// Shared unsigned multiplier with a registered product, used for all squares
// and start-term products of the walk. Depends on emr_pkg.
module emr_mul import emr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  // product holds until the next enabled issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== rtl/emr_pix.sv =====
// Pixel emitter: takes one point and drives its four mirrored pixels through
// an output register. Depends on emr_pkg.
module emr_pix import emr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pt_load,
  input  point_t                pt,
  input  logic [COORD_W-1:0]    center_x,
  input  logic [COORD_W-1:0]    center_y,
  input  logic [COLOUR_W-1:0]   colour,
  output logic                  pix_free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, pixel_colour, zero pad
  output logic                  m_tlast,  // last_of_point
  output logic                  m_tuser   // ellipse_done
);

  logic                pend;
  logic [1:0]          cnt;
  logic [POINT_W-1:0]  hold_x;
  logic [POINT_W-1:0]  hold_y;
  logic [COORD_W-1:0]  hold_cx;
  logic [COORD_W-1:0]  hold_cy;
  logic [COLOUR_W-1:0] hold_col;
  logic                hold_done;

  logic             fwd;
  logic             plus_x;
  logic             plus_y;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;

  assign pix_free = !pend;
  assign fwd      = pend && (!m_tvalid || m_tready);

  // mirror selection for the current pixel
  assign plus_x = (cnt == PIX_PP) || (cnt == PIX_PM);
  assign plus_y = (cnt == PIX_PP) || (cnt == PIX_MP);
  assign pix_x  = plus_x ? PIX_W'(hold_cx) + PIX_W'(hold_x) : PIX_W'(hold_cx) - PIX_W'(hold_x);
  assign pix_y  = plus_y ? PIX_W'(hold_cy) + PIX_W'(hold_y) : PIX_W'(hold_cy) - PIX_W'(hold_y);

  // control: pending point, pixel counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      cnt      <= PIX_PP;
      m_tvalid <= 1'b0;
    end else begin
      if (pt_load) begin
        pend <= 1'b1;
        cnt  <= PIX_PP;
      end else if (fwd) begin
        cnt <= cnt + 2'd1;
        if (cnt == PIX_MP) begin
          pend <= 1'b0;
        end
      end
      if (fwd) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // point and config snapshot taken with the step request
  always_ff @(posedge clk) begin
    if (pt_load) begin
      hold_x    <= pt.x;
      hold_y    <= pt.y;
      hold_done <= pt.done;
      hold_cx   <= center_x;
      hold_cy   <= center_y;
      hold_col  <= colour;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fwd) begin
      m_tdata <= OUT_DATA_W'({hold_col, pix_y, pix_x});
      m_tlast <= (cnt == PIX_MP);
      m_tuser <= hold_done;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    pt_load |-> !pend)
    else $error("point loaded while emitter busy");

  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    pt_load |=> (pend && cnt == PIX_PP))
    else $error("emitter did not restart on point load");

  a_valid_mid_point: assert property (@(posedge clk) disable iff (rst)
    (pend && cnt != PIX_PP) |-> m_tvalid)
    else $error("output gap inside a point");
`endif

endmodule

// ===== rtl/emr_core.sv =====
// Ellipse walker: sequencer plus datapath for the two-region midpoint walk,
// sharing one adder and the external multiplier. Depends on emr_pkg.
module emr_core import emr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [FIELD_W-1:0] x_radius,
  input  logic [FIELD_W-1:0] y_radius,
  input  logic               pix_free,
  output logic               pt_load,
  output point_t             pt,
  output logic               mul_en,
  output logic [MUL_W-1:0]   mul_a,
  output logic [MUL_W-1:0]   mul_b,
  input  logic [PROD_W-1:0]  mul_prod
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_SQ_RX = 22'h000002,
    S_SQ_RY = 22'h000004,
    S_RXRY  = 22'h000008,
    S_D1A   = 22'h000010,
    S_D1B   = 22'h000020,
    S_D1C   = 22'h000040,
    S_TRUNC = 22'h000080,
    S_R1A   = 22'h000100,
    S_R1B   = 22'h000200,
    S_R1C   = 22'h000400,
    S_R1D   = 22'h000800,
    S_TTX   = 22'h001000,
    S_TYM   = 22'h002000,
    S_TA    = 22'h004000,
    S_TB    = 22'h008000,
    S_TC    = 22'h010000,
    S_TD    = 22'h020000,
    S_R2A   = 22'h040000,
    S_R2B   = 22'h080000,
    S_R2C   = 22'h100000,
    S_R2D   = 22'h200000
  } state_t;

  state_t                   state;
  logic [RADIUS_BITS-1:0]   rx;
  logic [RADIUS_BITS-1:0]   ry;
  logic [SQ_W-1:0]          rx_sq;
  logic [SQ_W-1:0]          ry_sq;
  logic [POINT_W-1:0]       point_x;
  logic [POINT_W-1:0]       point_y;
  logic signed [GRAD_W-1:0] x_grad;
  logic signed [GRAD_W-1:0] y_grad;
  logic signed [ACC_W-1:0]  decision;
  logic [MUL_W-1:0]         sq_tmp;
  logic                     in_region_two;
  logic                     walk_active;
  logic                     dec_test;  // region one: d < 0; region two: d > 0

  logic                     accept;
  logic                     is_last;
  logic signed [GRAD_W-1:0] two_rx_sq;
  logic signed [GRAD_W-1:0] two_ry_sq;
  logic signed [ACC_W-1:0]  rx_sq_ext;
  logic signed [ACC_W-1:0]  ry_sq_ext;
  logic signed [ACC_W-1:0]  ry_sq_x4;
  logic signed [ACC_W-1:0]  xg_ext;
  logic signed [ACC_W-1:0]  yg_ext;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  prod_x4;
  logic [POINT_W-1:0]       ym_abs;
  logic [MUL_W-1:0]         tx;

  logic                     add_base;
  logic                     add_sub;
  logic                     add_shift;
  logic signed [ACC_W-1:0]  add_op;
  logic signed [ACC_W-1:0]  add_a;
  logic signed [ACC_W-1:0]  add_sum;
  logic signed [ACC_W-1:0]  add_res;

  // handshake and point handoff
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && pix_free;
  assign is_last  = (point_y == '0);
  assign pt_load  = accept && (kind == KIND_STEP) && walk_active;
  assign pt       = '{x: point_x, y: point_y, done: is_last};

  // operand forms
  assign two_rx_sq = signed'(GRAD_W'({rx_sq, 1'b0}));
  assign two_ry_sq = signed'(GRAD_W'({ry_sq, 1'b0}));
  assign rx_sq_ext = signed'(ACC_W'(rx_sq));
  assign ry_sq_ext = signed'(ACC_W'(ry_sq));
  assign ry_sq_x4  = signed'(ACC_W'({ry_sq, 2'b00}));
  assign xg_ext    = ACC_W'(x_grad);
  assign yg_ext    = ACC_W'(y_grad);
  assign prod_ext  = signed'(ACC_W'(mul_prod));
  assign prod_x4   = signed'(ACC_W'({mul_prod, 2'b00}));
  assign tx        = MUL_W'({point_x, 1'b1});
  // |y - 1|, which is 1 when y has reached zero
  assign ym_abs    = is_last ? POINT_W'(1) : point_y - POINT_W'(1);

  // multiplier issue
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_SQ_RX: begin
        mul_a = MUL_W'(rx);
        mul_b = MUL_W'(rx);
      end
      S_SQ_RY: begin
        mul_a = MUL_W'(ry);
        mul_b = MUL_W'(ry);
      end
      S_RXRY: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = MUL_W'(ry);
      end
      S_TTX: begin
        mul_a = tx;
        mul_b = tx;
      end
      S_TYM: begin
        mul_a = MUL_W'(ym_abs);
        mul_b = MUL_W'(ym_abs);
      end
      S_TA: begin
        mul_a = MUL_W'(ry_sq);
        mul_b = sq_tmp;
      end
      S_TB: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = sq_tmp;
      end
      S_TC: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = MUL_W'(ry_sq);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // shared decision adder: base +/- operand, optional divide by four
  always_comb begin
    add_base  = 1'b1;
    add_sub   = 1'b0;
    add_shift = 1'b0;
    add_op    = '0;
    case (state)
      S_D1A: begin
        add_base = 1'b0;
        add_sub  = 1'b1;
        add_op   = prod_x4;
      end
      S_D1B:   add_op = ry_sq_x4;
      S_D1C:   add_op = rx_sq_ext;
      S_TRUNC: begin
        // bias negative values so the shift rounds toward zero
        add_op    = decision[ACC_W-1] ? ACC_W'(3) : '0;
        add_shift = 1'b1;
      end
      S_R1B:   add_op = xg_ext;
      S_R1C: begin
        add_sub = 1'b1;
        add_op  = dec_test ? '0 : yg_ext;
      end
      S_R1D:   add_op = ry_sq_ext;
      S_TB: begin
        add_base = 1'b0;
        add_op   = prod_ext;
      end
      S_TC:    add_op = prod_x4;
      S_TD: begin
        add_sub = 1'b1;
        add_op  = prod_x4;
      end
      S_R2B:   add_op = rx_sq_ext;
      S_R2C: begin
        add_sub = 1'b1;
        add_op  = yg_ext;
      end
      S_R2D:   add_op = xg_ext;
      default: add_op = '0;
    endcase
  end

  assign add_a   = add_base ? decision : '0;
  assign add_sum = add_a + (add_op ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
  assign add_res = add_shift ? (add_sum >>> 2) : add_sum;

  // sequencer and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      walk_active   <= 1'b0;
      in_region_two <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_START) begin
              rx            <= RADIUS_BITS'(x_radius);
              ry            <= RADIUS_BITS'(y_radius);
              point_x       <= '0;
              point_y       <= POINT_W'(RADIUS_BITS'(y_radius));
              x_grad        <= '0;
              in_region_two <= 1'b0;
              walk_active   <= 1'b1;
              state         <= S_SQ_RX;
            end else if (walk_active) begin
              if (is_last) begin
                walk_active <= 1'b0;
              end else begin
                state <= in_region_two ? S_R2A : S_R1A;
              end
            end
          end
        end
        // start terms
        S_SQ_RX: state <= S_SQ_RY;
        S_SQ_RY: begin
          rx_sq <= SQ_W'(mul_prod);
          state <= S_RXRY;
        end
        S_RXRY: begin
          ry_sq <= SQ_W'(mul_prod);
          state <= S_D1A;
        end
        S_D1A: begin
          y_grad   <= GRAD_W'({mul_prod, 1'b0});
          decision <= add_res;
          state    <= S_D1B;
        end
        S_D1B: begin
          decision <= add_res;
          state    <= S_D1C;
        end
        S_D1C: begin
          decision <= add_res;
          state    <= S_TRUNC;
        end
        S_TRUNC: begin
          decision <= add_res;
          state    <= S_IDLE;
        end
        // region one advance
        S_R1A: begin
          point_x  <= point_x + POINT_W'(1);
          x_grad   <= x_grad + two_ry_sq;
          dec_test <= decision[ACC_W-1];
          if (!decision[ACC_W-1]) begin
            point_y <= point_y - POINT_W'(1);
            y_grad  <= y_grad - two_rx_sq;
          end
          state <= S_R1B;
        end
        S_R1B: begin
          decision <= add_res;
          state    <= S_R1C;
        end
        S_R1C: begin
          decision <= add_res;
          state    <= S_R1D;
        end
        S_R1D: begin
          decision <= add_res;
          if (!(x_grad < y_grad)) begin
            in_region_two <= 1'b1;
            state         <= S_TTX;
          end else begin
            state <= S_IDLE;
          end
        end
        // region two start term
        S_TTX: state <= S_TYM;
        S_TYM: begin
          sq_tmp <= MUL_W'(mul_prod);
          state  <= S_TA;
        end
        S_TA: begin
          sq_tmp <= MUL_W'(mul_prod);
          state  <= S_TB;
        end
        S_TB: begin
          decision <= add_res;
          state    <= S_TC;
        end
        S_TC: begin
          decision <= add_res;
          state    <= S_TD;
        end
        S_TD: begin
          decision <= add_res;
          state    <= S_TRUNC;
        end
        // region two advance
        S_R2A: begin
          point_y  <= point_y - POINT_W'(1);
          y_grad   <= y_grad - two_rx_sq;
          dec_test <= !decision[ACC_W-1] && (decision != '0);
          state    <= S_R2B;
        end
        S_R2B: begin
          decision <= add_res;
          if (!dec_test) begin
            point_x <= point_x + POINT_W'(1);
            x_grad  <= x_grad + two_ry_sq;
          end
          state <= S_R2C;
        end
        S_R2C: begin
          decision <= add_res;
          state    <= dec_test ? S_IDLE : S_R2D;
        end
        S_R2D: begin
          decision <= add_res;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_START) |=> (state == S_SQ_RX && walk_active && point_x == '0))
    else $error("start request did not set up the walk");

  a_final_point_ends: assert property (@(posedge clk) disable iff (rst)
    (pt_load && pt.done) |=> !walk_active)
    else $error("walk still active after the final point");

  a_region_two_grad: assert property (@(posedge clk) disable iff (rst)
    (walk_active && in_region_two && state == S_IDLE) |-> (x_grad >= y_grad))
    else $error("region two entered with x gradient below y gradient");
`endif

endmodule

// ===== rtl/ellipse_midpoint_rasterizer_unit.sv =====
// Midpoint ellipse rasterizer: top level with config registers, the walker,
// the shared multiplier and the pixel emitter.
// Depends on emr_pkg, emr_mul, emr_core, emr_pix.
//
// Usage:
//   Requests arrive on s_*; s_tuser is the kind (0 start, 1 step) and
//   s_tdata carries the radii. A start request loads the radii and
//   computes the start terms; it emits nothing. A step request
//   emits the four mirrored pixels of the current point on m_* in the order
//   (+x,+y), (-x,-y), (+x,-y), (-x,+y), m_tlast on the fourth, m_tuser on
//   all four pixels of the final point (y = 0). Steps when no walk is
//   active are taken and dropped.
//   A step's point is taken into the emitter's hold registers, and its
//   four pixels go out through the output register one per cycle while
//   m_tready is high. A new step request is taken only when the walker is
//   idle again; meanwhile it updates the decision through the one shared
//   adder, and the step that enters region two also forms the region-two
//   start term in the shared multiplier.
//   A stalled receiver holds the output register; s_tready stays low until
//   the emitter has handed out all pixels of the pending point.
//   Reset (synchronous, rst high) idles the walk and sets the centre to
//   (200, 200) and the colour to 15. Config writes via cfg_we are taken
//   at any edge; unused indexes are ignored.
module ellipse_midpoint_rasterizer_unit import emr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // x_radius, y_radius, zero pad
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, pixel_colour, zero pad
  output logic                  m_tlast,   // last_of_point
  output logic                  m_tuser,   // ellipse_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COORD_W-1:0]  center_x;
  logic [COORD_W-1:0]  center_y;
  logic [COLOUR_W-1:0] draw_colour;

  logic              pix_free;
  logic              pt_load;
  point_t            pt;
  logic              mul_en;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= CENTER_X_RST;
      center_y    <= CENTER_Y_RST;
      draw_colour <= COLOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x    <= COORD_W'(cfg_data);
        CFG_CENTER_Y: center_y    <= COORD_W'(cfg_data);
        CFG_COLOUR:   draw_colour <= COLOUR_W'(cfg_data);
        default:      ;
      endcase
    end
  end

  emr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  emr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .kind     (s_tuser),
    .x_radius (s_tdata[FIELD_W-1:0]),
    .y_radius (s_tdata[2*FIELD_W-1:FIELD_W]),
    .pix_free (pix_free),
    .pt_load  (pt_load),
    .pt       (pt),
    .mul_en   (mul_en),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_prod (mul_prod)
  );

  emr_pix u_pix (
    .clk      (clk),
    .rst      (rst),
    .pt_load  (pt_load),
    .pt       (pt),
    .center_x (center_x),
    .center_y (center_y),
    .colour   (draw_colour),
    .pix_free (pix_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
